// ===== rtl/rgb2hsl_pkg.sv =====
// Shared types and constants for the RGB to HSL converter.
// Used by the top level, the front end and the testbench; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package rgb2hsl_pkg;

    localparam int FRAC_BITS_DEF = 16;

    localparam int CH_W      = 8;
    localparam int HUE_W     = 9;
    localparam int SUM_W     = 9;
    localparam int DEN_W     = 10;
    localparam int HNUM_W    = 17;

    localparam int CH_MAX    = 255;
    localparam int SUM_MAX   = 510;
    localparam int SAT_SPLIT = 255;

    localparam int HUE_STEP  = 60;
    localparam int HUE_GREEN = 120;
    localparam int HUE_BLUE  = 240;
    localparam int HUE_FULL  = 360;

    typedef enum logic [1:0] {
        SEC_RED,
        SEC_GREEN,
        SEC_BLUE
    } t_sector;

    typedef struct packed {
        logic valid;
        logic grey;
    } t_ctl;

endpackage

`default_nettype wire

// ===== rtl/rgb_to_hsl_converter_core.sv =====
// A result passes from an accepted start through the front-end registers, the divider
// chain of one quotient bit per stage and the output register to o_strobe.
// Throughput: one pixel per clock; busy is always low.
// Reset (synchronous, active low) clears the valid pipeline and the strobe.
// The receiver cannot stall: each result is on the ports for one cycle.
// Top level of the RGB to HSL converter; uses rgb2hsl_pkg, rgb2hsl_front, rgb2hsl_div.
`timescale 1ns / 1ps
`default_nettype none

module rgb_to_hsl_converter_core #(
    parameter int FRAC_BITS = rgb2hsl_pkg::FRAC_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [rgb2hsl_pkg::CH_W-1:0]      i_red,
    input  wire logic [rgb2hsl_pkg::CH_W-1:0]      i_green,
    input  wire logic [rgb2hsl_pkg::CH_W-1:0]      i_blue,
    output logic                                   o_strobe,
    output logic [rgb2hsl_pkg::HUE_W-1:0]          o_hue_deg,
    output logic [FRAC_BITS:0]                     o_sat_frac,
    output logic [FRAC_BITS:0]                     o_light_frac
);

    localparam int DEN_W = rgb2hsl_pkg::DEN_W;
    localparam int HUE_W = rgb2hsl_pkg::HUE_W;
    localparam int QUO_W = FRAC_BITS + 1;
    localparam int NUM_W = DEN_W + QUO_W;

    rgb2hsl_pkg::t_ctl   front_ctl;
    logic [NUM_W-1:0]    hue_num;
    logic [DEN_W-1:0]    hue_den;
    logic [NUM_W-1:0]    sat_num;
    logic [DEN_W-1:0]    sat_den;
    logic [QUO_W-1:0]    front_light;
    logic [QUO_W-1:0]    hue_quo;
    logic [QUO_W-1:0]    sat_quo;

    rgb2hsl_pkg::t_ctl   r_ctl [0:QUO_W-1];
    logic [QUO_W-1:0]    r_light_d [0:QUO_W-1];
    logic                r_strobe;
    logic [HUE_W-1:0]    r_hue;
    logic [QUO_W-1:0]    r_sat;
    logic [QUO_W-1:0]    r_light;

    assign busy = 1'b0;

    rgb2hsl_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (start & ~busy),
        .i_red       (i_red),
        .i_green     (i_green),
        .i_blue      (i_blue),
        .o_ctl       (front_ctl),
        .o_hue_num   (hue_num),
        .o_hue_den   (hue_den),
        .o_sat_num   (sat_num),
        .o_sat_den   (sat_den),
        .o_light     (front_light)
    );

    rgb2hsl_div #(
        .DEN_W (DEN_W),
        .QUO_W (QUO_W)
    ) u_div_hue (
        .i_clk (i_clk),
        .i_num (hue_num),
        .i_den (hue_den),
        .o_quo (hue_quo)
    );

    rgb2hsl_div #(
        .DEN_W (DEN_W),
        .QUO_W (QUO_W)
    ) u_div_sat (
        .i_clk (i_clk),
        .i_num (sat_num),
        .i_den (sat_den),
        .o_quo (sat_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < QUO_W; k++) begin
                r_ctl[k] <= '0;
            end
        end else begin
            r_ctl[0] <= front_ctl;
            for (int k = 1; k < QUO_W; k++) begin
                r_ctl[k] <= r_ctl[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_light_d[0] <= front_light;
        for (int k = 1; k < QUO_W; k++) begin
            r_light_d[k] <= r_light_d[k-1];
        end
    end

    // A grey pixel has no defined hue or saturation; both are forced to zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_ctl[QUO_W-1].valid;
        end
        r_hue   <= r_ctl[QUO_W-1].grey ? '0 : hue_quo[HUE_W-1:0];
        r_sat   <= r_ctl[QUO_W-1].grey ? '0 : sat_quo;
        r_light <= r_light_d[QUO_W-1];
    end

    assign o_strobe     = r_strobe;
    assign o_hue_deg    = r_hue;
    assign o_sat_frac   = r_sat;
    assign o_light_frac = r_light;

endmodule

`default_nettype wire

// ===== rtl/rgb2hsl_front.sv =====
// Front end of the converter: maximum, minimum and sector, then the rounded
// dividends and divisors for hue and saturation, and the lightness. Uses rgb2hsl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rgb2hsl_front #(
    parameter int FRAC_BITS = rgb2hsl_pkg::FRAC_BITS_DEF
) (
    input  wire logic                                          i_clk,
    input  wire logic                                          i_rst_n,
    input  wire logic                                          i_valid,
    input  wire logic [rgb2hsl_pkg::CH_W-1:0]                  i_red,
    input  wire logic [rgb2hsl_pkg::CH_W-1:0]                  i_green,
    input  wire logic [rgb2hsl_pkg::CH_W-1:0]                  i_blue,
    output rgb2hsl_pkg::t_ctl                                  o_ctl,
    output logic [rgb2hsl_pkg::DEN_W+FRAC_BITS:0]              o_hue_num,
    output logic [rgb2hsl_pkg::DEN_W-1:0]                      o_hue_den,
    output logic [rgb2hsl_pkg::DEN_W+FRAC_BITS:0]              o_sat_num,
    output logic [rgb2hsl_pkg::DEN_W-1:0]                      o_sat_den,
    output logic [FRAC_BITS:0]                                 o_light
);

    localparam int CH_W    = rgb2hsl_pkg::CH_W;
    localparam int SUM_W   = rgb2hsl_pkg::SUM_W;
    localparam int DEN_W   = rgb2hsl_pkg::DEN_W;
    localparam int HNUM_W  = rgb2hsl_pkg::HNUM_W;
    localparam int NUM_W   = DEN_W + FRAC_BITS + 1;
    localparam int LIGHT_W = FRAC_BITS + 1;

    logic [CH_W-1:0]         mx;
    logic [CH_W-1:0]         mn;
    rgb2hsl_pkg::t_sector    n_sector;
    logic signed [CH_W:0]    n_diff;
    logic [CH_W-1:0]         n_d;
    logic [SUM_W-1:0]        n_sum;

    logic                    r_valid1;
    rgb2hsl_pkg::t_sector    r_sector;
    logic signed [CH_W:0]    r_diff;
    logic [CH_W-1:0]         r_d;
    logic [SUM_W-1:0]        r_sum;

    logic                    neg;
    logic [CH_W-1:0]         mag;
    logic [HNUM_W-1:0]       m60;
    logic [HNUM_W-1:0]       base;
    logic [HNUM_W-1:0]       hue_num;
    logic [SUM_W-1:0]        sat_den;
    logic [1:0]              l_whole;
    logic [CH_W-1:0]         l_rest;
    logic [4*CH_W-1:0]       l_rep;

    rgb2hsl_pkg::t_ctl       n_ctl;
    logic [NUM_W-1:0]        n_hue_num;
    logic [DEN_W-1:0]        n_hue_den;
    logic [NUM_W-1:0]        n_sat_num;
    logic [DEN_W-1:0]        n_sat_den;
    logic [LIGHT_W-1:0]      n_light;

    rgb2hsl_pkg::t_ctl       r_ctl;
    logic [NUM_W-1:0]        r_hue_num;
    logic [DEN_W-1:0]        r_hue_den;
    logic [NUM_W-1:0]        r_sat_num;
    logic [DEN_W-1:0]        r_sat_den;
    logic [LIGHT_W-1:0]      r_light;

    // Ties for the largest channel go to red, then to green.
    always_comb begin
        if (i_red >= i_green && i_red >= i_blue) begin
            n_sector = rgb2hsl_pkg::SEC_RED;
            mx       = i_red;
            n_diff   = $signed({1'b0, i_green}) - $signed({1'b0, i_blue});
        end else if (i_green >= i_blue) begin
            n_sector = rgb2hsl_pkg::SEC_GREEN;
            mx       = i_green;
            n_diff   = $signed({1'b0, i_blue}) - $signed({1'b0, i_red});
        end else begin
            n_sector = rgb2hsl_pkg::SEC_BLUE;
            mx       = i_blue;
            n_diff   = $signed({1'b0, i_red}) - $signed({1'b0, i_green});
        end
        mn = i_red;
        if (i_green < mn) begin
            mn = i_green;
        end
        if (i_blue < mn) begin
            mn = i_blue;
        end
        n_d   = mx - mn;
        n_sum = {1'b0, mx} + {1'b0, mn};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid1 <= 1'b0;
        end else begin
            r_valid1 <= i_valid;
        end
        r_sector <= n_sector;
        r_diff   <= n_diff;
        r_d      <= n_d;
        r_sum    <= n_sum;
    end

    // Hue numerator is sector base times d plus or minus sixty times the
    // channel difference; a negative red hue takes the full-turn base.
    always_comb begin
        neg = r_diff[CH_W];
        mag = neg ? CH_W'(-r_diff) : r_diff[CH_W-1:0];
        m60 = HNUM_W'(mag) * HNUM_W'(rgb2hsl_pkg::HUE_STEP);
        case (r_sector)
            rgb2hsl_pkg::SEC_RED: begin
                base = neg ? HNUM_W'(r_d) * HNUM_W'(rgb2hsl_pkg::HUE_FULL) : '0;
            end
            rgb2hsl_pkg::SEC_GREEN: begin
                base = HNUM_W'(r_d) * HNUM_W'(rgb2hsl_pkg::HUE_GREEN);
            end
            rgb2hsl_pkg::SEC_BLUE: begin
                base = HNUM_W'(r_d) * HNUM_W'(rgb2hsl_pkg::HUE_BLUE);
            end
            default: begin
                base = '0;
            end
        endcase
        hue_num = neg ? base - m60 : base + m60;

        if (r_sum < SUM_W'(rgb2hsl_pkg::SAT_SPLIT)) begin
            sat_den = r_sum;
        end else begin
            sat_den = SUM_W'(rgb2hsl_pkg::SUM_MAX) - r_sum;
        end

        // Lightness is the sum over 255, halved. The sum splits into whole
        // multiples of 255 and a rest; the rest over 255 is the rest repeated
        // as base-256 digits, so its fraction bits are copies of the rest and
        // the first bit past them rounds.
        if (r_sum >= SUM_W'(rgb2hsl_pkg::SUM_MAX)) begin
            l_whole = 2'd2;
            l_rest  = '0;
        end else if (r_sum >= SUM_W'(rgb2hsl_pkg::CH_MAX)) begin
            l_whole = 2'd1;
            l_rest  = CH_W'(r_sum - SUM_W'(rgb2hsl_pkg::CH_MAX));
        end else begin
            l_whole = 2'd0;
            l_rest  = r_sum[CH_W-1:0];
        end
        l_rep   = {4{l_rest}};
        n_light = (LIGHT_W'(l_whole) << (FRAC_BITS - 1))
                + LIGHT_W'(l_rep[4*CH_W-1 -: FRAC_BITS-1])
                + LIGHT_W'(l_rep[4*CH_W-FRAC_BITS]);

        n_hue_num   = (NUM_W'(hue_num) << 1) + NUM_W'(r_d);
        n_hue_den   = {1'b0, r_d, 1'b0};
        n_sat_num   = (NUM_W'(r_d) << (FRAC_BITS + 1)) + NUM_W'(sat_den);
        n_sat_den   = {sat_den, 1'b0};

        n_ctl.valid = r_valid1;
        n_ctl.grey  = (r_d == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= n_ctl;
        end
        r_hue_num   <= n_hue_num;
        r_hue_den   <= n_hue_den;
        r_sat_num   <= n_sat_num;
        r_sat_den   <= n_sat_den;
        r_light     <= n_light;
    end

    assign o_ctl       = r_ctl;
    assign o_hue_num   = r_hue_num;
    assign o_hue_den   = r_hue_den;
    assign o_sat_num   = r_sat_num;
    assign o_sat_den   = r_sat_den;
    assign o_light     = r_light;

endmodule

`default_nettype wire

// ===== rtl/rgb2hsl_div.sv =====
// Pipelined restoring divider that produces one quotient bit per stage.
// The top DEN_W bits of the dividend must be below the divisor. No package use.
`timescale 1ns / 1ps
`default_nettype none

module rgb2hsl_div #(
    parameter int DEN_W = 10,
    parameter int QUO_W = 17
) (
    input  wire logic                     i_clk,
    input  wire logic [DEN_W+QUO_W-1:0]   i_num,
    input  wire logic [DEN_W-1:0]         i_den,
    output logic [QUO_W-1:0]              o_quo
);

    localparam int NUM_W = DEN_W + QUO_W;

    logic [DEN_W-1:0] r_rem  [0:QUO_W-2];
    logic [DEN_W-1:0] r_den  [0:QUO_W-2];
    logic [QUO_W-1:0] r_bits [0:QUO_W-1];

    for (genvar k = 0; k < QUO_W; k++) begin : g_stage
        logic [DEN_W-1:0] rem_in;
        logic [DEN_W-1:0] den_in;
        logic [QUO_W-1:0] bits_in;
        logic [DEN_W:0]   trial;
        logic [DEN_W:0]   rest;
        logic             take;

        if (k == 0) begin : g_first
            assign rem_in  = i_num[NUM_W-1 -: DEN_W];
            assign bits_in = i_num[QUO_W-1:0];
            assign den_in  = i_den;
        end else begin : g_next
            assign rem_in  = r_rem[k-1];
            assign bits_in = r_bits[k-1];
            assign den_in  = r_den[k-1];
        end

        assign trial = {rem_in, bits_in[QUO_W-1]};
        assign take  = (trial >= {1'b0, den_in});
        assign rest  = trial - {1'b0, den_in};

        always_ff @(posedge i_clk) begin
            r_bits[k] <= {bits_in[QUO_W-2:0], take};
        end

        if (k < QUO_W - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                r_rem[k] <= take ? rest[DEN_W-1:0] : trial[DEN_W-1:0];
                r_den[k] <= den_in;
            end
        end
    end

    assign o_quo = r_bits[QUO_W-1];

endmodule

`default_nettype wire

// ===== rtl/rgb2hsl_checker.sv =====
// Port-level checks for rgb_to_hsl_converter_core, attached by the bind below.
// Uses only the top level's ports and its FRAC_BITS parameter.
`timescale 1ns / 1ps
`default_nettype none

module rgb2hsl_checker #(
    parameter int FRAC_BITS = 16
) (
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 start,
    input wire logic                 busy,
    input wire logic [7:0]           i_red,
    input wire logic [7:0]           i_green,
    input wire logic [7:0]           i_blue,
    input wire logic                 o_strobe,
    input wire logic [8:0]           o_hue_deg,
    input wire logic [FRAC_BITS:0]   o_sat_frac,
    input wire logic [FRAC_BITS:0]   o_light_frac
);

    localparam int LAT = FRAC_BITS + 4;
    localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

    // Every accepted transaction produces exactly one result.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_strobe)
        else $error("accepted transaction gave no result at the expected cycle");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(start && !busy) |-> ##LAT !o_strobe)
        else $error("result strobe without an accepted transaction");

    a_grey_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_red == i_green && i_green == i_blue)
        |-> ##LAT (o_hue_deg == 9'd0 && o_sat_frac == '0))
        else $error("grey pixel gave nonzero hue or saturation");

    a_ranges: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_hue_deg <= 9'd360 && o_sat_frac <= ONE && o_light_frac <= ONE))
        else $error("result field out of range");

endmodule

bind rgb_to_hsl_converter_core rgb2hsl_checker #(
    .FRAC_BITS (FRAC_BITS)
) u_rgb2hsl_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .i_red        (i_red),
    .i_green      (i_green),
    .i_blue       (i_blue),
    .o_strobe     (o_strobe),
    .o_hue_deg    (o_hue_deg),
    .o_sat_frac   (o_sat_frac),
    .o_light_frac (o_light_frac)
);

`default_nettype wire

// ===== dv/rgb_to_hsl_converter_core_test.sv =====
// Self-checking testbench for rgb_to_hsl_converter_core: directed pixels, then random ones.
// Results are checked in acceptance order: known rows against the table, others against a built-in HSL predictor.
// Depends on rgb2hsl_pkg and the converter RTL only.
`timescale 1ns / 1ps

module rgb_to_hsl_converter_core_test;

    localparam int FRAC_BITS   = rgb2hsl_pkg::FRAC_BITS_DEF;
    localparam int CH_W        = rgb2hsl_pkg::CH_W;
    localparam int HUE_W       = rgb2hsl_pkg::HUE_W;
    localparam int SL_W        = FRAC_BITS + 1;
    localparam int LATENCY     = FRAC_BITS + 4;
    localparam int N_DIRECTED  = 23;
    localparam int N_RANDOM    = 1250;
    localparam int CALM_TAIL   = 150;
    localparam int CYCLE_LIMIT = 200000;

    localparam logic [FRAC_BITS:0] SL_ONE  = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [FRAC_BITS:0] SL_HALF = {2'b01, {(FRAC_BITS-1){1'b0}}};

    typedef struct packed {
        logic [HUE_W-1:0]   hue;
        logic [FRAC_BITS:0] sat;
        logic [FRAC_BITS:0] light;
    } t_hsl;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic            known;
        t_hsl            hsl;
    } t_pixel_row;

    // Rows marked known carry their result; the rest are left to the predictor.
    localparam t_pixel_row PIXEL_TABLE [N_DIRECTED] = '{
        '{8'd0,   8'd0,   8'd0,   1'b1, '{9'd0,   '0,     '0}},
        '{8'd255, 8'd255, 8'd255, 1'b1, '{9'd0,   '0,     SL_ONE}},
        '{8'd255, 8'd0,   8'd0,   1'b1, '{9'd0,   SL_ONE, SL_HALF}},
        '{8'd0,   8'd255, 8'd0,   1'b1, '{9'd120, SL_ONE, SL_HALF}},
        '{8'd0,   8'd0,   8'd255, 1'b1, '{9'd240, SL_ONE, SL_HALF}},
        '{8'd255, 8'd255, 8'd0,   1'b1, '{9'd60,  SL_ONE, SL_HALF}},
        '{8'd0,   8'd255, 8'd255, 1'b1, '{9'd180, SL_ONE, SL_HALF}},
        '{8'd255, 8'd0,   8'd255, 1'b1, '{9'd300, SL_ONE, SL_HALF}},
        '{8'd128, 8'd128, 8'd128, 1'b0, '0},
        '{8'd255, 8'd0,   8'd1,   1'b0, '0},
        '{8'd255, 8'd1,   8'd0,   1'b0, '0},
        '{8'd1,   8'd0,   8'd0,   1'b0, '0},
        '{8'd0,   8'd0,   8'd1,   1'b0, '0},
        '{8'd254, 8'd255, 8'd254, 1'b0, '0},
        '{8'd127, 8'd128, 8'd127, 1'b0, '0},
        '{8'd127, 8'd127, 8'd126, 1'b0, '0},
        '{8'd1,   8'd2,   8'd3,   1'b0, '0},
        '{8'd200, 8'd100, 8'd50,  1'b0, '0},
        '{8'd50,  8'd200, 8'd100, 1'b0, '0},
        '{8'd100, 8'd50,  8'd200, 1'b0, '0},
        '{8'd85,  8'd170, 8'd255, 1'b0, '0},
        '{8'd170, 8'd85,  8'd0,   1'b0, '0},
        '{8'd0,   8'd1,   8'd255, 1'b0, '0}
    };

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic [CH_W-1:0]     i_red = '0;
    logic [CH_W-1:0]     i_green = '0;
    logic [CH_W-1:0]     i_blue = '0;
    logic                o_strobe;
    logic [HUE_W-1:0]    o_hue_deg;
    logic [FRAC_BITS:0]  o_sat_frac;
    logic [FRAC_BITS:0]  o_light_frac;

    logic                row_known = 1'b0;
    t_hsl                row_hsl = '0;

    t_hsl                hsl_pending [$];
    int                  n_pixels_sent = 0;
    int                  n_pixels_taken = 0;
    int                  n_mismatches = 0;
    int                  n_cycles = 0;

    rgb_to_hsl_converter_core #(
        .FRAC_BITS(FRAC_BITS)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_red       (i_red),
        .i_green     (i_green),
        .i_blue      (i_blue),
        .o_strobe    (o_strobe),
        .o_hue_deg   (o_hue_deg),
        .o_sat_frac  (o_sat_frac),
        .o_light_frac(o_light_frac)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic longint unsigned round_frac(input longint unsigned num,
                                                   input longint unsigned den);
        return (2 * (num << FRAC_BITS) + den) / (2 * den);
    endfunction

    function automatic t_hsl hsl_of_pixel(input logic [CH_W-1:0] r, g, b);
        longint unsigned      rr, gg, bb, mx, mn, d, sum, num;
        rgb2hsl_pkg::t_sector sector;
        t_hsl                 res;
        rr = r;
        gg = g;
        bb = b;
        mx = rr;
        mn = rr;
        if (gg > mx) mx = gg;
        if (bb > mx) mx = bb;
        if (gg < mn) mn = gg;
        if (bb < mn) mn = bb;
        d = mx - mn;
        sum = mx + mn;
        sector = (mx == rr) ? rgb2hsl_pkg::SEC_RED
               : ((mx == gg) ? rgb2hsl_pkg::SEC_GREEN : rgb2hsl_pkg::SEC_BLUE);
        res = '0;
        res.light = SL_W'(round_frac(sum, rgb2hsl_pkg::SUM_MAX));
        if (d != 0) begin
            res.sat = SL_W'(round_frac(d, (sum < rgb2hsl_pkg::SAT_SPLIT)
                                          ? sum : rgb2hsl_pkg::SUM_MAX - sum));
            case (sector)
                rgb2hsl_pkg::SEC_RED: begin
                    num = (gg >= bb) ? rgb2hsl_pkg::HUE_STEP * (gg - bb)
                                     : rgb2hsl_pkg::HUE_FULL * d
                                       - rgb2hsl_pkg::HUE_STEP * (bb - gg);
                end
                rgb2hsl_pkg::SEC_GREEN: begin
                    num = (bb >= rr) ? rgb2hsl_pkg::HUE_GREEN * d
                                       + rgb2hsl_pkg::HUE_STEP * (bb - rr)
                                     : rgb2hsl_pkg::HUE_GREEN * d
                                       - rgb2hsl_pkg::HUE_STEP * (rr - bb);
                end
                default: begin
                    num = (rr >= gg) ? rgb2hsl_pkg::HUE_BLUE * d
                                       + rgb2hsl_pkg::HUE_STEP * (rr - gg)
                                     : rgb2hsl_pkg::HUE_BLUE * d
                                       - rgb2hsl_pkg::HUE_STEP * (gg - rr);
                end
            endcase
            res.hue = HUE_W'((2 * num + d) / (2 * d));
        end
        return res;
    endfunction

    // Mixes uniform pixels with greys, ties, extremes and hues just below a full turn.
    function automatic logic [3*CH_W-1:0] random_pixel();
        logic [CH_W-1:0] a, b, c;
        a = CH_W'($urandom);
        b = CH_W'($urandom);
        c = CH_W'($urandom);
        case ($urandom_range(0, 9))
            4: begin
                a = ($urandom_range(0, 2) == 0) ? 8'd0
                  : (($urandom_range(0, 1) == 0) ? 8'd255 : a);
                b = ($urandom_range(0, 2) == 0) ? 8'd0
                  : (($urandom_range(0, 1) == 0) ? 8'd255 : b);
                c = ($urandom_range(0, 2) == 0) ? 8'd0
                  : (($urandom_range(0, 1) == 0) ? 8'd255 : c);
            end
            5: begin
                b = a;
                c = a;
            end
            6: begin
                b = a;
                c = CH_W'($urandom_range(0, 32'(a)));
            end
            7: begin
                a = CH_W'($urandom_range(128, 255));
                b = CH_W'($urandom_range(0, 32'(a) - 4));
                c = b + CH_W'($urandom_range(1, 3));
                return {a, b, c};
            end
            8: begin
                b = (a > 252) ? a - CH_W'($urandom_range(0, 3)) : a + CH_W'($urandom_range(0, 3));
                c = (a > 252) ? a - CH_W'($urandom_range(0, 3)) : a + CH_W'($urandom_range(0, 3));
            end
            9: begin
                a = a >> 1;
                b = b >> 1;
                c = c >> 2;
            end
            default: begin
            end
        endcase
        case ($urandom_range(0, 2))
            0: return {a, b, c};
            1: return {b, c, a};
            default: return {c, a, b};
        endcase
    endfunction

    task automatic send_pixel(input logic [CH_W-1:0] r, g, b, input logic known,
                              input t_hsl hsl);
        start <= 1'b1;
        i_red <= r;
        i_green <= g;
        i_blue <= b;
        row_known <= known;
        row_hsl <= hsl;
        n_pixels_sent++;
        do @(negedge i_clk); while (n_pixels_taken != n_pixels_sent);
    endtask

    task automatic hold_off(input int cycles);
        start <= 1'b0;
        i_red <= CH_W'($urandom);
        i_green <= CH_W'($urandom);
        i_blue <= CH_W'($urandom);
        repeat (cycles) @(negedge i_clk);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        do @(negedge i_clk); while (hsl_pending.size() != 0);
    endtask

    always @(posedge i_clk) begin : result_checker
        t_hsl want;
        n_cycles <= n_cycles + 1;
        if (n_cycles == CYCLE_LIMIT) begin
            $display("%0t: timed out after %0d cycles", $time, n_cycles);
            $display("*** FAILED ***");
            $finish;
        end else if (i_rst_n) begin
            if (o_strobe) begin
                if (hsl_pending.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got hue %0d sat %0d light %0d",
                             $time, o_hue_deg, o_sat_frac, o_light_frac);
                    n_mismatches++;
                end else begin
                    want = hsl_pending.pop_front();
                    if (o_hue_deg !== want.hue) begin
                        $display("%0t: hue expected %0d, got %0d", $time, want.hue, o_hue_deg);
                        n_mismatches++;
                    end
                    if (o_sat_frac !== want.sat) begin
                        $display("%0t: saturation expected %0d, got %0d",
                                 $time, want.sat, o_sat_frac);
                        n_mismatches++;
                    end
                    if (o_light_frac !== want.light) begin
                        $display("%0t: lightness expected %0d, got %0d",
                                 $time, want.light, o_light_frac);
                        n_mismatches++;
                    end
                end
            end
            if (start && !busy) begin
                hsl_pending.push_back(row_known ? row_hsl
                                                : hsl_of_pixel(i_red, i_green, i_blue));
                n_pixels_taken <= n_pixels_taken + 1;
            end
        end
    end

    initial begin : pixel_source
        logic [3*CH_W-1:0] pixel;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int i = 0; i < N_DIRECTED; i++) begin
            send_pixel(PIXEL_TABLE[i].red, PIXEL_TABLE[i].green, PIXEL_TABLE[i].blue,
                       PIXEL_TABLE[i].known, PIXEL_TABLE[i].hsl);
            if ($urandom_range(0, 3) == 0) hold_off($urandom_range(1, 14));
        end
        wait_drained();

        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == N_RANDOM / 2) begin
                wait_drained();
            end else if (i < N_RANDOM - CALM_TAIL && i % 200 > 60
                         && $urandom_range(0, 4) == 0) begin
                hold_off($urandom_range(1, 14));
            end
            pixel = random_pixel();
            send_pixel(pixel[3*CH_W-1:2*CH_W], pixel[2*CH_W-1:CH_W], pixel[CH_W-1:0],
                       1'b0, '0);
        end

        wait_drained();
        repeat (LATENCY + 8) @(negedge i_clk);
        if (n_mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/rgb2hsl_pkg.sv
rtl/rgb2hsl_front.sv
rtl/rgb2hsl_div.sv
rtl/rgb_to_hsl_converter_core.sv
rtl/rgb2hsl_checker.sv
dv/rgb_to_hsl_converter_core_test.sv
